// File: rtl/ppbb_pkg.sv
// ----------------------------------------------------------------------------
// ppbb_pkg
// Shared types and constants for the ping-pong block buffer: channel payloads
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ppbb_pkg;

    // Fixed field widths
    localparam int SAMPLE_W         = 64;
    localparam int COUNT_W          = 3;
    localparam int CFG_W            = 7;
    localparam int SAMPLES_PER_ITEM = 4;
    localparam int IDX_W            = $clog2(SAMPLES_PER_ITEM);

    // Reset value of the block size register
    localparam logic [CFG_W-1:0] BLOCK_SIZE_RST = 7'd64;

    // Item mode codes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    // Input transaction payload
    typedef struct packed {
        logic                mode;
        logic [COUNT_W-1:0]  count;
        logic [SAMPLE_W-1:0] sample_0;
        logic [SAMPLE_W-1:0] sample_1;
        logic [SAMPLE_W-1:0] sample_2;
        logic [SAMPLE_W-1:0] sample_3;
    } ppbb_in_t;

    // Result transaction payload
    typedef struct packed {
        logic                ok;
        logic [SAMPLE_W-1:0] data_word;
        logic                last;
    } ppbb_out_t;

    // Controller to datapath
    typedef struct packed {
        logic cap;        // capture the input transaction
        logic wr_word;    // store one sample, advance sample index
        logic wr_commit;  // advance write pointer, mark block full if done
        logic rd_issue;   // read one block word from storage
        logic out_data;   // load result register with read word
        logic out_resp;   // load result register with a single response
        logic resp_ok;    // ok bit of that response
        logic rd_commit;  // free the read block, toggle read side
    } ppbb_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_read;    // captured item is a block read
        logic wr_ok;      // captured write fits
        logic rd_ok;      // current read block is full
        logic idx_last;   // sample index at last sample of item
        logic rd_more;    // block words left to issue
        logic rdv;        // read data register holds a word
        logic rd_last;    // that word is the block's last
        logic out_free;   // result register can take a new transaction
    } ppbb_status_t;

endpackage

// File: rtl/ppbb_ctrl.sv
// ----------------------------------------------------------------------------
// ppbb_ctrl
// Sequencer for the ping-pong block buffer: takes one item at a time, checks
// it, then steps the datapath through sample stores or a block stream, or sends a failure response.
// ----------------------------------------------------------------------------
module ppbb_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ppbb_pkg::ppbb_status_t sts,
    output ppbb_pkg::ppbb_cmd_t    cmd
);
    import ppbb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WRITE,
        ST_RESP,
        ST_READ
    } state_t;

    state_t state_reg, state_next;
    logic   ok_reg, ok_next;

    // Command decode
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        ok_next    = ok_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.cap    = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.is_read) begin
                    if (sts.rd_ok) begin
                        state_next = ST_READ;
                    end else begin
                        ok_next    = 1'b0;
                        state_next = ST_RESP;
                    end
                end else if (sts.wr_ok) begin
                    state_next = ST_WRITE;
                end else begin
                    ok_next    = 1'b0;
                    state_next = ST_RESP;
                end
            end
            ST_WRITE: begin
                cmd.wr_word = 1'b1;
                if (sts.idx_last) begin
                    cmd.wr_commit = 1'b1;
                    ok_next       = 1'b1;
                    state_next    = ST_RESP;
                end
            end
            ST_RESP: begin
                cmd.resp_ok = ok_reg;
                if (sts.out_free) begin
                    cmd.out_resp = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_READ: begin
                // word in the read register moves on when the result slot frees
                cmd.out_data = sts.rdv && sts.out_free;
                // next read goes out once the read register is empty or draining
                cmd.rd_issue = sts.rd_more && (!sts.rdv || cmd.out_data);
                if (cmd.out_data && sts.rd_last) begin
                    cmd.rd_commit = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ok_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ok_reg    <= ok_next;
        end
    end

endmodule

// File: rtl/ppbb_datapath.sv
// ----------------------------------------------------------------------------
// ppbb_datapath
// Sample storage for both blocks, write/read pointers, full flags, the held
// input transaction and the result register.
// ----------------------------------------------------------------------------
module ppbb_datapath #(
    parameter int BLOCK_DEPTH = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [ppbb_pkg::CFG_W-1:0]    cfg_wr_data,
    input  ppbb_pkg::ppbb_in_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output ppbb_pkg::ppbb_out_t           m_data,
    input  ppbb_pkg::ppbb_cmd_t           cmd,
    output ppbb_pkg::ppbb_status_t        sts
);
    import ppbb_pkg::*;

    localparam int PTR_W   = $clog2(BLOCK_DEPTH);
    localparam int SZ_W    = $clog2(BLOCK_DEPTH + 1);
    localparam int SUM_W   = SZ_W + 1;
    localparam int MEM_DEP = 2 << PTR_W;

    // Storage: side bit above the word position
    logic [SAMPLE_W-1:0] sample_mem [MEM_DEP];

    logic [CFG_W-1:0]    block_size_reg;
    logic [1:0]          full_reg;
    logic                rd_side_reg;
    logic                wr_side_reg;
    logic [PTR_W-1:0]    wr_pos_reg;
    ppbb_in_t            item_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [SZ_W-1:0]     rd_cnt_reg;
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                rdv_reg;
    logic                rd_last_reg;
    logic                m_valid_reg;
    ppbb_out_t           m_data_reg;

    logic [SZ_W-1:0]     size;
    logic [SUM_W-1:0]    wr_end;
    logic [SUM_W-1:0]    wr_addr_sum;
    logic [PTR_W:0]      wr_addr;
    logic [PTR_W:0]      rd_addr;
    logic [SAMPLE_W-1:0] wr_sample;
    logic                rd_issue_last;
    logic                out_free;

    // Effective block size: zero acts as one, clamp to the block depth
    always_comb begin
        if (block_size_reg == '0) begin
            size = SZ_W'(1);
        end else if (block_size_reg > CFG_W'(BLOCK_DEPTH)) begin
            size = SZ_W'(BLOCK_DEPTH);
        end else begin
            size = SZ_W'(block_size_reg);
        end
    end

    // Write side arithmetic
    assign wr_end      = SUM_W'(wr_pos_reg) + SUM_W'(item_reg.count);
    assign wr_addr_sum = SUM_W'(wr_pos_reg) + SUM_W'(idx_reg);
    assign wr_addr     = {wr_side_reg, wr_addr_sum[PTR_W-1:0]};

    // Sample picked by the index
    always_comb begin
        case (idx_reg)
            2'd0:    wr_sample = item_reg.sample_0;
            2'd1:    wr_sample = item_reg.sample_1;
            2'd2:    wr_sample = item_reg.sample_2;
            default: wr_sample = item_reg.sample_3;
        endcase
    end

    // Read side
    assign rd_addr       = {rd_side_reg, rd_cnt_reg[PTR_W-1:0]};
    assign rd_issue_last = (rd_cnt_reg + SZ_W'(1)) == size;
    assign out_free      = !m_valid_reg || m_ready;

    // Status to controller
    always_comb begin
        sts.is_read  = (item_reg.mode == MODE_READ);
        sts.wr_ok    = !full_reg[wr_side_reg]
                       && (item_reg.count != '0)
                       && (item_reg.count <= COUNT_W'(SAMPLES_PER_ITEM))
                       && (wr_end <= SUM_W'(size));
        sts.rd_ok    = full_reg[rd_side_reg];
        sts.idx_last = (COUNT_W'(idx_reg) + COUNT_W'(1)) == item_reg.count;
        sts.rd_more  = (rd_cnt_reg != size);
        sts.rdv      = rdv_reg;
        sts.rd_last  = rd_last_reg;
        sts.out_free = out_free;
    end

    // Storage write and registered read
    always_ff @(posedge aclk) begin
        if (cmd.wr_word) begin
            sample_mem[wr_addr] <= wr_sample;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= sample_mem[rd_addr];
            rd_last_reg <= rd_issue_last;
        end
    end

    // Held transaction and counters
    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            item_reg <= s_data;
        end
        if (cmd.cap) begin
            idx_reg    <= '0;
            rd_cnt_reg <= '0;
        end else begin
            if (cmd.wr_word) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.rd_issue) begin
                rd_cnt_reg <= rd_cnt_reg + SZ_W'(1);
            end
        end
    end

    // Block flags, sides, pointer and block size
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_size_reg <= BLOCK_SIZE_RST;
            full_reg       <= '0;
            rd_side_reg    <= 1'b0;
            wr_side_reg    <= 1'b0;
            wr_pos_reg     <= '0;
        end else if (cfg_wr_en) begin
            block_size_reg <= cfg_wr_data;
            full_reg       <= '0;
            rd_side_reg    <= 1'b0;
            wr_side_reg    <= 1'b0;
            wr_pos_reg     <= '0;
        end else begin
            if (cmd.wr_commit) begin
                if (wr_end >= SUM_W'(size)) begin
                    full_reg[wr_side_reg] <= 1'b1;
                    wr_side_reg           <= !wr_side_reg;
                    wr_pos_reg            <= '0;
                end else begin
                    wr_pos_reg <= wr_end[PTR_W-1:0];
                end
            end
            if (cmd.rd_commit) begin
                full_reg[rd_side_reg] <= 1'b0;
                rd_side_reg           <= !rd_side_reg;
            end
        end
    end

    // Read data valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rdv_reg <= 1'b0;
        end else if (cmd.rd_issue) begin
            rdv_reg <= 1'b1;
        end else if (cmd.out_data) begin
            rdv_reg <= 1'b0;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_data || cmd.out_resp) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_data) begin
            m_data_reg.ok        <= 1'b1;
            m_data_reg.data_word <= rd_data_reg;
            m_data_reg.last      <= rd_last_reg;
        end else if (cmd.out_resp) begin
            m_data_reg.ok        <= cmd.resp_ok;
            m_data_reg.data_word <= '0;
            m_data_reg.last      <= 1'b1;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/ping_pong_block_buffer.sv
// ----------------------------------------------------------------------------
// ping_pong_block_buffer
// Two-block ping-pong buffer of 64-bit sample words.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel (valid/ready) carries one item: mode 0 appends 1..4 samples to
//   the current write block, mode 1 streams out the current full read block.
//   m_* channel (valid/ready) returns one transaction per write item and per
//   failed read (last set), or one transaction per block word on a read.
//   cfg_wr_en/cfg_wr_data set the block size and clear flags and pointers;
//   write it only while the block is idle.
// Timing:
//   One item is handled at a time. A write item stores one sample per cycle
//   through the one storage write port; s_ready stays low from acceptance
//   until the item's response is loaded. A read streams one word per cycle
//   while m_ready is high, once its first storage read is done. A failed or
//   rejected item goes from its check straight to its response. Sink stalls
//   hold back the response and the read stream.
// Reset: aresetn low clears flags, sides, write position, block size to 64
//   and drops m_valid. Storage is not cleared; it is read only once written.
// Stall: the result register holds while m_ready is low; the read stream
//   pauses with it and resumes without loss.
// ----------------------------------------------------------------------------
module ping_pong_block_buffer #(
    parameter int BLOCK_DEPTH = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [ppbb_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  ppbb_pkg::ppbb_in_t         s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output ppbb_pkg::ppbb_out_t        m_data
);
    import ppbb_pkg::*;

    ppbb_cmd_t    cmd;
    ppbb_status_t sts;

    // Sequencer
    ppbb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Storage, pointers and result register
    ppbb_datapath #(
        .BLOCK_DEPTH (BLOCK_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule
